>>> src/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACT_WIDTH      = 3;
    localparam int ST_WIDTH       = 2;

    localparam logic [ACT_WIDTH-1:0] ACT_LENGTH = 3'd0;
    localparam logic [ACT_WIDTH-1:0] ACT_READ   = 3'd1;
    localparam logic [ACT_WIDTH-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACT_WIDTH-1:0] ACT_INSERT = 3'd3;
    localparam logic [ACT_WIDTH-1:0] ACT_DELETE = 3'd4;

    localparam logic [ST_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [ST_WIDTH-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [ST_WIDTH-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_WIDTH-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                load_req;
        logic                p_load;
        logic                p_step;
        logic                rd_en;
        logic                cmp_en;
        logic                shift_en;
        logic                put_en;
        logic                cnt_dec;
        logic                st_load;
        logic [ST_WIDTH-1:0] st_code;
        logic                out_load;
    } ple_cmd_t;

    typedef struct packed {
        logic [ACT_WIDTH-1:0] action;
        logic                 rd_ok;
        logic                 ins_ok;
        logic                 full;
        logic                 active;
        logic                 cmp_pend;
        logic                 match;
        logic                 wr_pend;
        logic                 out_free;
    } ple_stat_t;

endpackage

`default_nettype wire

>>> src/ple_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the list words; depends on nothing.
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/ple_dpath.sv
// Datapath of the positional list engine: request registers, walk pointer,
// entry memory, shift and compare pipeline, count and output register.
// Depends on ple_pkg and ple_ram.
`default_nettype none

module ple_dpath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ple_pkg::ple_cmd_t                    cmd,
    output ple_pkg::ple_stat_t                        stat,
    input  wire logic [ple_pkg::ACT_WIDTH-1:0]        action,
    input  wire logic [$clog2(CAPACITY+2)-1:0]        position,
    input  wire logic signed [DATA_WIDTH-1:0]         value,
    input  wire logic                                 out_stall,
    output logic                                      out_valid,
    output logic      [ple_pkg::ST_WIDTH-1:0]         status,
    output logic signed [DATA_WIDTH-1:0]              data_out,
    output logic      [$clog2(CAPACITY+2)-1:0]        found_position,
    output logic      [$clog2(CAPACITY+2)-1:0]        length
);

    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 2);

    logic [ACT_WIDTH-1:0]  action_reg;
    logic [PW-1:0]         pos_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [PW-1:0]         count_reg;
    logic [PW-1:0]         p_reg;
    logic                  wr_pend_reg;
    logic [AW-1:0]         wr_addr_reg;
    logic                  cmp_pend_reg;
    logic [PW-1:0]         cmp_pos_reg;
    logic [PW-1:0]         found_reg;
    logic [ST_WIDTH-1:0]   status_reg;
    logic                  out_valid_reg;
    logic [ST_WIDTH-1:0]   out_status_reg;
    logic [DATA_WIDTH-1:0] out_data_reg;
    logic [PW-1:0]         out_found_reg;
    logic [PW-1:0]         out_length_reg;

    logic                  is_insert;
    logic                  match;
    logic [PW-1:0]         p_init;
    logic [PW-1:0]         p_minus1;
    logic [PW-1:0]         p_minus2;
    logic [PW-1:0]         pos_minus1;
    logic [PW-1:0]         cnt_plus1;
    logic [AW-1:0]         shift_addr;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [DATA_WIDTH-1:0] rd_data;

    assign is_insert  = (action_reg == ACT_INSERT);
    assign p_minus1   = p_reg - 1'b1;
    assign p_minus2   = p_reg - PW'(2);
    assign pos_minus1 = pos_reg - 1'b1;
    assign cnt_plus1  = count_reg + 1'b1;
    assign match      = cmp_pend_reg && (rd_data == value_reg);

    always_comb
    begin
        case (action_reg)
            ACT_FIND:   p_init = PW'(1);
            ACT_INSERT: p_init = count_reg;
            ACT_DELETE: p_init = pos_reg + 1'b1;
            default:    p_init = pos_reg;
        endcase
    end

    // Insert moves entry p-1 up to p; delete moves it down to p-2.
    assign shift_addr = is_insert ? p_reg[AW-1:0] : p_minus2[AW-1:0];

    assign mem_wr_en   = wr_pend_reg | cmd.put_en;
    assign mem_wr_addr = wr_pend_reg ? wr_addr_reg : pos_minus1[AW-1:0];
    assign mem_wr_data = wr_pend_reg ? rd_data : value_reg;

    ple_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (p_minus1[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        stat.action   = action_reg;
        stat.rd_ok    = (pos_reg != '0) && (pos_reg <= count_reg);
        stat.ins_ok   = (pos_reg != '0) && (pos_reg <= cnt_plus1);
        stat.full     = (count_reg == PW'(CAPACITY));
        stat.active   = is_insert ? (p_reg >= pos_reg) : (p_reg <= count_reg);
        stat.cmp_pend = cmp_pend_reg;
        stat.match    = match;
        stat.wr_pend  = wr_pend_reg;
        stat.out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            action_reg <= action;
            pos_reg    <= position;
            value_reg  <= value;
        end
        if (cmd.p_load)
        begin
            p_reg <= p_init;
        end
        else if (cmd.p_step)
        begin
            p_reg <= is_insert ? p_minus1 : (p_reg + 1'b1);
        end
        if (cmd.shift_en)
        begin
            wr_addr_reg <= shift_addr;
        end
        if (cmd.cmp_en)
        begin
            cmp_pos_reg <= p_reg;
        end
        if (cmd.load_req)
        begin
            found_reg <= '0;
        end
        else if (match)
        begin
            found_reg <= cmp_pos_reg;
        end
        if (cmd.load_req)
        begin
            status_reg <= ST_OK;
        end
        else if (cmd.st_load)
        begin
            status_reg <= cmd.st_code;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= (action_reg == ACT_READ && status_reg == ST_OK) ? rd_data : '0;
            out_found_reg  <= found_reg;
            out_length_reg <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg  <= cmd.shift_en;
            cmp_pend_reg <= cmd.cmp_en;
            if (cmd.put_en)
            begin
                count_reg <= cnt_plus1;
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign data_out       = out_data_reg;
    assign found_position = out_found_reg;
    assign length         = out_length_reg;

endmodule

`default_nettype wire

>>> src/ple_ctrl.sv
// Controller of the positional list engine: sequences decode, read, scan,
// shift, put and result hand-off through commands to the datapath.
// Depends on ple_pkg.
`default_nettype none

module ple_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ple_pkg::ple_stat_t stat,
    output ple_pkg::ple_cmd_t       cmd
);

    import ple_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_PUT    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.p_load = 1'b1;
                state_next = S_FINISH;
                case (stat.action)
                    ACT_READ:
                    begin
                        if (stat.rd_ok)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_BAD_POS;
                        end
                    end
                    ACT_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    ACT_INSERT:
                    begin
                        if (!stat.ins_ok)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_BAD_POS;
                        end
                        else if (stat.full)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (stat.rd_ok)
                        begin
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = ST_BAD_POS;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.active)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.cmp_en = 1'b1;
                    cmd.p_step = 1'b1;
                end
                else if (!stat.cmp_pend)
                begin
                    cmd.st_load = 1'b1;
                    cmd.st_code = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                if (stat.active)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.shift_en = 1'b1;
                    cmd.p_step   = 1'b1;
                end
                else if (!stat.wr_pend)
                begin
                    if (stat.action == ACT_INSERT)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_PUT:
            begin
                cmd.put_en = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> src/positional_list_engine.sv
// Positional list engine: an ordered list of signed words held in one RAM.
// The input channel (in_valid, in_stall) carries one request beat: action,
// position and value. The output channel (out_valid, out_stall) returns one
// result beat per request: status, data_out, found_position and length.
// Length requests, unused action codes and failed requests go from decode
// straight to the finish state; a read passes through the read state first.
// Find walks the list one entry per cycle.
// Insert at position p shifts count - p + 1 entries up and delete shifts
// count - p entries down, one RAM read and one RAM write per cycle; the
// single RAM read port sets these rates. One request is in work at a time;
// in_stall is high from acceptance until the result is placed in the output
// register.
// A finished result waits in the output register while out_stall is high;
// the next request can be accepted and processed meanwhile, and its own
// result waits in the engine until the register frees.
// Reset empties the list and clears out_valid; entry storage is
// not cleared, since only positions below the count are ever read.
// Depends on ple_pkg, ple_ctrl, ple_dpath and ple_ram.
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [ple_pkg::ACT_WIDTH-1:0]        action,
    input  wire logic [$clog2(CAPACITY+2)-1:0]        position,
    input  wire logic signed [DATA_WIDTH-1:0]         value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic      [ple_pkg::ST_WIDTH-1:0]         status,
    output logic signed [DATA_WIDTH-1:0]              data_out,
    output logic      [$clog2(CAPACITY+2)-1:0]        found_position,
    output logic      [$clog2(CAPACITY+2)-1:0]        length
);

    import ple_pkg::*;

    ple_cmd_t  cmd;
    ple_stat_t stat;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    ple_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .position       (position),
        .value          (value),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .length         (length)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("engine accepted a beat but did not become busy");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.wr_pend && cmd.put_en))
        else $error("shift write and insert write collided");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length <= CAPACITY))
        else $error("reported length exceeds capacity");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwrote a beat still waiting");
`endif

endmodule

`default_nettype wire

>>> test/tb_positional_list_engine.sv
// Self-checking testbench for positional_list_engine: request beats go in
// through the valid/stall input channel, and each result beat is checked against
// a list model kept here. Depends on ple_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int DW = DATA_WIDTH_DEF;
    localparam int PW = $clog2(CAP + 2);
    localparam int NUM_ITEMS = 1950;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_DEPTH = 16;

    localparam logic [ACT_WIDTH-1:0] ACT_SPARE5 = 3'd5;
    localparam logic [ACT_WIDTH-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [ACT_WIDTH-1:0] ACT_SPARE7 = 3'd7;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

    typedef struct packed {
        logic [ACT_WIDTH-1:0] act;
        logic [PW-1:0]        pos;
        logic signed [DW-1:0] val;
    } request_t;

    typedef struct packed {
        logic [ST_WIDTH-1:0]  st;
        logic signed [DW-1:0] data;
        logic [PW-1:0]        found;
        logic [PW-1:0]        len;
    } result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [ACT_WIDTH-1:0] action = ACT_LENGTH;
    logic [PW-1:0]        position = '0;
    logic signed [DW-1:0] value = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [ST_WIDTH-1:0]  status;
    logic signed [DW-1:0] data_out;
    logic [PW-1:0]        found_position;
    logic [PW-1:0]        length;

    request_t pending_q[$];
    result_t  expected_q[$];

    logic signed [DW-1:0] list_words [CAP];
    int list_len = 0;
    int peak_len = 0;
    int status_tally [4] = '{0, 0, 0, 0};
    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    logic hold_off = 1'b0;

    int gen_len = 0;
    int queued_n = 0;
    logic signed [DW-1:0] value_pool [POOL_DEPTH];
    int pool_fill = 0;
    int pool_next = 0;

    wire calm = (beats_in >= 700) && (beats_in < 1000);

    positional_list_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .length         (length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t apply_request(input logic [ACT_WIDTH-1:0] act,
                                              input logic [PW-1:0] pos,
                                              input logic signed [DW-1:0] val);
        result_t r;
        int p;
        int k;
        r = '0;
        r.st = ST_OK;
        p = int'(pos);
        case (act)
            ACT_READ:
            begin
                if (p >= 1 && p <= list_len)
                    r.data = list_words[p-1];
                else
                    r.st = ST_BAD_POS;
            end
            ACT_FIND:
            begin
                r.st = ST_NOT_FOUND;
                for (k = list_len - 1; k >= 0; k--)
                begin
                    if (list_words[k] == val)
                    begin
                        r.found = PW'(k + 1);
                        r.st = ST_OK;
                    end
                end
            end
            ACT_INSERT:
            begin
                if (p < 1 || p > list_len + 1)
                    r.st = ST_BAD_POS;
                else if (list_len >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    for (k = list_len; k >= p; k--)
                        list_words[k] = list_words[k-1];
                    list_words[p-1] = val;
                    list_len++;
                end
            end
            ACT_DELETE:
            begin
                if (p >= 1 && p <= list_len)
                begin
                    for (k = p; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
                else
                    r.st = ST_BAD_POS;
            end
            default:
            begin
            end
        endcase
        r.len = PW'(list_len);
        status_tally[r.st]++;
        if (list_len > peak_len)
            peak_len = list_len;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH at %0t ns, result beat %0d: %s", $time, beats_out, what);
    endtask

    task automatic queue_request(input logic [ACT_WIDTH-1:0] act, input int pos,
                                 input logic signed [DW-1:0] val);
        pending_q.push_back('{act: act, pos: PW'(pos), val: val});
        queued_n++;
        if (act == ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAP)
        begin
            gen_len++;
            value_pool[pool_next] = val;
            pool_next = (pool_next + 1) % POOL_DEPTH;
            if (pool_fill < POOL_DEPTH)
                pool_fill++;
        end
        else if (act == ACT_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    function automatic logic signed [DW-1:0] pick_value();
        int roll;
        logic signed [DW-1:0] v;
        roll = $urandom_range(99);
        if (roll < 35)
            v = int'($urandom_range(8)) - 4;
        else if (roll < 65 && pool_fill > 0)
            v = value_pool[$urandom_range(pool_fill - 1)];
        else if (roll < 72)
        begin
            case ($urandom_range(3))
                0: v = {1'b1, {(DW-1){1'b0}}};
                1: v = {1'b0, {(DW-1){1'b1}}};
                2: v = '0;
                default: v = '1;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    task automatic queue_random(input phase_e kind);
        int roll;
        int w_ins;
        int w_del;
        int rest;
        int p;
        case (kind)
            PH_GROW:
            begin
                w_ins = 70;
                w_del = 10;
            end
            PH_SHRINK:
            begin
                w_ins = 12;
                w_del = 68;
            end
            default:
            begin
                w_ins = 30;
                w_del = 28;
            end
        endcase
        rest = 100 - w_ins - w_del;
        if ($urandom_range(99) < 8)
        begin
            queue_request(ACT_WIDTH'($urandom_range(7)), $urandom_range(CAP + 1),
                          pick_value());
            return;
        end
        if (gen_len > 0 && $urandom_range(9) != 0)
            p = $urandom_range(gen_len, 1);
        else
            p = $urandom_range(CAP + 1);
        roll = $urandom_range(99);
        if (roll < w_ins)
        begin
            case ($urandom_range(9))
                0, 1, 2: p = gen_len + 1;
                3, 4: p = 1;
                5: p = $urandom_range(CAP + 1);
                default: p = $urandom_range(gen_len + 1, 1);
            endcase
            queue_request(ACT_INSERT, p, pick_value());
        end
        else if (roll < w_ins + w_del)
            queue_request(ACT_DELETE, p, pick_value());
        else if (roll < w_ins + w_del + rest * 2 / 5)
            queue_request(ACT_READ, p, pick_value());
        else if (roll < w_ins + w_del + rest * 4 / 5)
            queue_request(ACT_FIND, p, pick_value());
        else
            queue_request(ACT_LENGTH, p, pick_value());
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= ACT_LENGTH;
            position <= '0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(apply_request(action, position, value));
                void'(pending_q.pop_front());
                beats_in <= beats_in + 1;
            end
            if (in_valid && in_stall)
            begin
            end
            else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 20))
            begin
                in_valid <= 1'b1;
                action   <= pending_q[0].act;
                position <= pending_q[0].pos;
                value    <= pending_q[0].val;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                beats_out <= beats_out + 1;
                if (expected_q.size() == 0)
                    report_mismatch("result beat with no request outstanding");
                else
                begin
                    want = expected_q.pop_front();
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.st));
                    if (data_out !== want.data)
                        report_mismatch($sformatf("data_out %0d, expected %0d",
                                                  data_out, want.data));
                    if (found_position !== want.found)
                        report_mismatch($sformatf("found_position %0d, expected %0d",
                                                  found_position, want.found));
                    if (length !== want.len)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  length, want.len));
                end
            end
            out_stall <= hold_off || (!calm && $urandom_range(99) < 20);
        end
    end

    // The receiver stops taking results for a long stretch so that the
    // engine backs up and stalls its input while requests keep coming.
    initial
    begin
        wait (beats_in >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        phase_e kind;
        int phase_len;
        bit first_phase;

        queue_request(ACT_LENGTH, 0, 0);
        queue_request(ACT_READ, 1, 0);
        queue_request(ACT_DELETE, 1, 0);
        queue_request(ACT_FIND, 0, 0);
        queue_request(ACT_INSERT, 0, 5);
        queue_request(ACT_INSERT, 2, 6);
        queue_request(ACT_INSERT, 1, {1'b1, {(DW-1){1'b0}}});
        queue_request(ACT_INSERT, 2, {1'b0, {(DW-1){1'b1}}});
        queue_request(ACT_INSERT, 1, -1);
        queue_request(ACT_INSERT, 2, 0);
        for (int i = 0; i <= 5; i++)
            queue_request(ACT_READ, i, 0);
        queue_request(ACT_FIND, 0, {1'b0, {(DW-1){1'b1}}});
        queue_request(ACT_FIND, 0, 12345);
        queue_request(ACT_DELETE, 2, 0);
        queue_request(ACT_DELETE, 4, 0);
        queue_request(ACT_SPARE5, 1, 7);
        queue_request(ACT_SPARE6, CAP + 1, -7);
        queue_request(ACT_SPARE7, CAP, '1);
        queue_request(ACT_READ, CAP + 1, 0);
        queue_request(ACT_INSERT, CAP + 1, 9);

        kind = PH_GROW;
        first_phase = 1'b1;
        while (queued_n < NUM_ITEMS)
        begin
            phase_len = first_phase ? 160 : $urandom_range(140, 30);
            if (phase_len > NUM_ITEMS - queued_n)
                phase_len = NUM_ITEMS - queued_n;
            first_phase = 1'b0;
            repeat (phase_len) queue_random(kind);
            kind = phase_e'($urandom_range(2));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d requests checked: ok %0d, bad position %0d, not found %0d, full %0d",
                 beats_in, status_tally[ST_OK], status_tally[ST_BAD_POS],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL]);
        $display("longest list %0d of %0d entries, one receiver hold-off of %0d cycles",
                 peak_len, CAP, HOLD_CYCLES);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
